// ----- hw/rtl/wmf_pkg.sv -----
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared types and fixed constants of the windowed median filter.
// ----------------------------------------------------------------------------
package wmf_pkg;

    // Fixed field widths, height limit and job queue depth
    localparam int PORT_PIX_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int ROW_W      = 12;
    localparam int COL_MAX_W  = 12;
    localparam int SLOT_MAX_W = 4;
    localparam int MASK_MAX_W = 16;
    localparam int DIM_W      = 13;
    localparam int WIN_W      = 4;
    localparam int MAX_HEIGHT = 4096;
    localparam int JOBQ_DEPTH = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } cfg_idx_t;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [WIN_W-1:0] n;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } cfg_t;

    // One output position handed from the front to the back
    typedef struct packed {
        logic [ROW_W-1:0]      row;
        logic [COL_MAX_W-1:0]  col;
        logic [SLOT_MAX_W-1:0] slot;
        logic [MASK_MAX_W-1:0] mask;
        logic                  row_last;
        logic                  frame_last;
    } job_t;

    // Ring slot of base slot plus a small signed offset
    function automatic int ring_step(input int base, input int off, input int ring);
        int v;
        v = base + off;
        if (v < 0) begin
            v = v + ring;
        end
        else if (v >= ring) begin
            v = v - ring;
        end
        return v;
    endfunction

endpackage

// ----- hw/rtl/wmf_ram.sv -----
// ----------------------------------------------------------------------------
// wmf_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/wmf_job_queue.sv -----
// ----------------------------------------------------------------------------
// wmf_job_queue
// Short queue of output jobs between front and back; also reports the
// line store slots that its waiting jobs still read.
// ----------------------------------------------------------------------------
module wmf_job_queue #(
    parameter int RING = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wmf_pkg::job_t     din,
    input  logic              pop,
    output wmf_pkg::job_t     dout,
    output logic              full,
    output logic              empty,
    output logic [RING-1:0]   mask_or
);

    localparam int PTR_W = $clog2(wmf_pkg::JOBQ_DEPTH);
    localparam int CNT_W = $clog2(wmf_pkg::JOBQ_DEPTH + 1);

    wmf_pkg::job_t    ent_reg [wmf_pkg::JOBQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full  = (cnt_reg == CNT_W'(wmf_pkg::JOBQ_DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = ent_reg[rd_ptr_reg];

    // Collect slots of occupied entries
    always_comb
    begin
        logic [PTR_W-1:0] offs;
        mask_or = '0;
        for (int i = 0; i < wmf_pkg::JOBQ_DEPTH; i++)
        begin
            offs = PTR_W'(i) - rd_ptr_reg;
            if (CNT_W'(offs) < cnt_reg)
            begin
                mask_or = mask_or | ent_reg[i].mask[RING-1:0];
            end
        end
    end

    // Store pushed beats
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= din;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/wmf_front.sv -----
// ----------------------------------------------------------------------------
// wmf_front
// Configuration registers, input and output raster counters, line store
// writes, and the decision which input beat releases an output job.
// ----------------------------------------------------------------------------
module wmf_front #(
    parameter int MAX_WINDOW = 7,
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [wmf_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [wmf_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic                                    push,
    input  logic                                    action,
    input  logic [wmf_pkg::PORT_PIX_W-1:0]          pixel_in,
    output logic                                    full,
    input  logic                                    q_full,
    input  logic [MAX_WINDOW:0]                     pend_mask,
    output logic                                    job_valid,
    output wmf_pkg::job_t                           job,
    output logic                                    wr_en,
    output logic [$clog2(MAX_WINDOW+1)-1:0]         wr_slot,
    output logic [$clog2(MAX_WIDTH)-1:0]            wr_col,
    output logic [PIXEL_BITS-1:0]                   wr_data,
    output wmf_pkg::cfg_t                           cfg
);

    localparam int RING   = MAX_WINDOW + 1;
    localparam int SLOT_W = $clog2(RING);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int DW     = wmf_pkg::DIM_W;

    wmf_pkg::cfg_t                cfg_reg, cfg_next;
    logic [wmf_pkg::ROW_W-1:0]    in_row_reg, in_row_next;
    logic [COL_W-1:0]             in_col_reg, in_col_next;
    logic [SLOT_W-1:0]            in_slot_reg, in_slot_next;
    logic [wmf_pkg::ROW_W-1:0]    out_row_reg, out_row_next;
    logic [COL_W-1:0]             out_col_reg, out_col_next;
    logic [SLOT_W-1:0]            out_slot_reg, out_slot_next;
    logic                         in_ahead_reg, in_ahead_next;

    logic [wmf_pkg::WIN_W-1:0]    half;
    logic [wmf_pkg::WIN_W-1:0]    below;
    logic [DW-1:0]                w_m1;
    logic [DW-1:0]                h_m1;
    logic                         accept;
    logic                         emit;

    assign cfg     = cfg_reg;
    assign half    = cfg_reg.n >> 1;
    assign below   = cfg_reg.n - wmf_pkg::WIN_W'(1) - half;
    assign w_m1    = cfg_reg.w - DW'(1);
    assign h_m1    = cfg_reg.h - DW'(1);

    // Hold input while the queue is full or the write slot is still read
    assign full    = q_full || pend_mask[in_slot_reg];
    assign accept  = push && !full;

    assign wr_en   = accept && !action;
    assign wr_slot = in_slot_reg;
    assign wr_col  = in_col_reg;
    assign wr_data = PIXEL_BITS'(pixel_in);

    // Step the raster counters and classify the beat
    always_comb
    begin
        logic [wmf_pkg::ROW_W-1:0] orow;
        logic [COL_W-1:0]          ocol;
        logic [SLOT_W-1:0]         oslot;
        logic                      ahead;
        logic                      silent;
        logic                      ready;
        logic                      rl;
        logic [DW-1:0]             nr;
        logic [DW-1:0]             nc;
        int                        rr;
        int                        sl;
        logic [2:0]                v3;
        logic [10:0]               v11;

        cfg_next      = cfg_reg;
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_slot_next  = in_slot_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_slot_next = out_slot_reg;
        in_ahead_next = in_ahead_reg;
        emit          = 1'b0;
        job           = '0;
        v3            = cfg_data[2:0];
        v11           = cfg_data[10:0];

        orow  = out_row_reg;
        ocol  = out_col_reg;
        oslot = out_slot_reg;
        ahead = in_ahead_reg;

        // A pixel after a finished frame starts the next frame
        if (!action && in_ahead_reg)
        begin
            orow  = '0;
            ocol  = '0;
            oslot = '0;
            ahead = 1'b0;
        end

        silent = action && !in_ahead_reg && (out_row_reg == '0) && (out_col_reg == '0)
                 && (in_row_reg == '0) && (in_col_reg == '0);

        // Advance the input position on a pixel
        if (!action)
        begin
            if (DW'(in_col_reg) == w_m1)
            begin
                in_col_next = '0;
                if (DW'(in_row_reg) == h_m1)
                begin
                    in_row_next  = '0;
                    in_slot_next = '0;
                    ahead        = 1'b1;
                end
                else
                begin
                    in_row_next  = in_row_reg + wmf_pkg::ROW_W'(1);
                    in_slot_next = (in_slot_reg == SLOT_W'(RING - 1)) ? '0
                                 : in_slot_reg + SLOT_W'(1);
                end
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
        end

        // Output is ready once its lower right window corner has arrived
        nr = DW'(orow) + DW'(below);
        if (nr > h_m1)
        begin
            nr = h_m1;
        end
        nc = DW'(ocol) + DW'(below);
        if (nc > w_m1)
        begin
            nc = w_m1;
        end
        ready = ahead || (DW'(in_row_next) > nr)
                || ((DW'(in_row_next) == nr) && (DW'(in_col_next) > nc));
        emit  = accept && !silent && ready;

        // Build the job and its slot mask
        rl             = (DW'(ocol) == w_m1);
        job.row        = orow;
        job.col        = wmf_pkg::COL_MAX_W'(ocol);
        job.slot       = wmf_pkg::SLOT_MAX_W'(oslot);
        job.row_last   = rl;
        job.frame_last = rl && (DW'(orow) == h_m1);
        for (int s = 0; s < MAX_WINDOW; s++)
        begin
            rr = int'(orow) + s - int'(half);
            if ((s < int'(cfg_reg.n)) && (rr >= 0) && (rr < int'(cfg_reg.h)))
            begin
                sl = wmf_pkg::ring_step(int'(oslot), s - int'(half), RING);
                job.mask[wmf_pkg::SLOT_MAX_W'(sl)] = 1'b1;
            end
        end

        // Advance the output position
        if (accept)
        begin
            out_row_next  = orow;
            out_col_next  = ocol;
            out_slot_next = oslot;
            if (emit)
            begin
                if (rl)
                begin
                    out_col_next = '0;
                    if (job.frame_last)
                    begin
                        out_row_next  = '0;
                        out_slot_next = '0;
                        ahead         = 1'b0;
                    end
                    else
                    begin
                        out_row_next  = orow + wmf_pkg::ROW_W'(1);
                        out_slot_next = (oslot == SLOT_W'(RING - 1)) ? '0
                                      : oslot + SLOT_W'(1);
                    end
                end
                else
                begin
                    out_col_next = ocol + COL_W'(1);
                end
            end
            in_ahead_next = ahead;
        end
        else
        begin
            in_row_next  = in_row_reg;
            in_col_next  = in_col_reg;
            in_slot_next = in_slot_reg;
        end

        // Register write clamps the value and restarts the frame
        if (cfg_we)
        begin
            unique case (cfg_index)
                wmf_pkg::CFG_WINDOW:
                begin
                    cfg_next.n = (v3 == '0) ? wmf_pkg::WIN_W'(1)
                               : (int'(v3) > MAX_WINDOW) ? wmf_pkg::WIN_W'(MAX_WINDOW)
                               : wmf_pkg::WIN_W'(v3);
                end
                wmf_pkg::CFG_WIDTH:
                begin
                    cfg_next.w = (v11 == '0) ? DW'(1)
                               : (int'(v11) > MAX_WIDTH) ? DW'(MAX_WIDTH) : DW'(v11);
                end
                wmf_pkg::CFG_HEIGHT:
                begin
                    cfg_next.h = (cfg_data == '0) ? DW'(1)
                               : (int'(cfg_data) > wmf_pkg::MAX_HEIGHT)
                                 ? DW'(wmf_pkg::MAX_HEIGHT) : DW'(cfg_data);
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
            if ((cfg_index == wmf_pkg::CFG_WINDOW) || (cfg_index == wmf_pkg::CFG_WIDTH)
                || (cfg_index == wmf_pkg::CFG_HEIGHT))
            begin
                in_row_next   = '0;
                in_col_next   = '0;
                in_slot_next  = '0;
                out_row_next  = '0;
                out_col_next  = '0;
                out_slot_next = '0;
                in_ahead_next = 1'b0;
            end
        end
    end

    assign job_valid = emit;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.n    <= wmf_pkg::WIN_W'((MAX_WINDOW < 3) ? MAX_WINDOW : 3);
            cfg_reg.w    <= DW'((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024);
            cfg_reg.h    <= DW'(1024);
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            in_ahead_reg <= 1'b0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_slot_reg  <= in_slot_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_slot_reg <= out_slot_next;
            in_ahead_reg <= in_ahead_next;
        end
    end

    // A pixel never lands in a slot that a pending job still reads
    a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !pend_mask[wr_slot])
        else $error("line store write hits a slot in use");

    // A job is only released when the queue has room
    a_job_room: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> !q_full)
        else $error("job released into full queue");

endmodule

// ----- hw/rtl/wmf_back.sv -----
// ----------------------------------------------------------------------------
// wmf_back
// Executes one job: gathers the clipped window column by column from the
// line store, selects the upper median bit by bit, holds the result beat.
// ----------------------------------------------------------------------------
module wmf_back #(
    parameter int MAX_WINDOW = 7,
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  wmf_pkg::cfg_t                           cfg,
    input  logic                                    q_empty,
    input  wmf_pkg::job_t                           q_head,
    output logic                                    q_pop,
    output logic [MAX_WINDOW:0]                     busy_mask,
    output logic                                    rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]            rd_col,
    input  logic [MAX_WINDOW:0][PIXEL_BITS-1:0]     rd_data,
    input  logic                                    pop,
    output logic                                    empty,
    output logic [wmf_pkg::PORT_PIX_W-1:0]          median_out,
    output logic                                    row_last,
    output logic                                    frame_last
);

    localparam int RING   = MAX_WINDOW + 1;
    localparam int SLOT_W = $clog2(RING);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WIN_N  = MAX_WINDOW * MAX_WINDOW;
    localparam int CW     = $clog2(WIN_N + 1);
    localparam int NW     = $clog2(MAX_WINDOW + 1);
    localparam int BW     = (PIXEL_BITS > 1) ? $clog2(PIXEL_BITS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOAD   = 4'b0010,
        ST_SELECT = 4'b0100,
        ST_DONE   = 4'b1000
    } st_t;

    st_t                              st_reg, st_next;
    wmf_pkg::job_t                    job_reg, job_next;
    logic [NW-1:0]                    t_reg, t_next;
    logic                             rd_v_reg, rd_v_next;
    logic [NW-1:0]                    rd_t_reg, rd_t_next;
    logic                             rd_ok_reg, rd_ok_next;
    logic [WIN_N-1:0][PIXEL_BITS-1:0] win_reg, win_next;
    logic [WIN_N-1:0]                 vld_reg, vld_next;
    logic [CW-1:0]                    cnt_reg, cnt_next;
    logic [WIN_N-1:0]                 cand_reg, cand_next;
    logic [CW-1:0]                    k_reg, k_next;
    logic [BW-1:0]                    b_reg, b_next;
    logic [PIXEL_BITS-1:0]            res_reg, res_next;
    logic                             out_valid_reg, out_valid_next;
    logic [wmf_pkg::PORT_PIX_W-1:0]   out_med_reg;
    logic                             out_rl_reg;
    logic                             out_fl_reg;

    logic [wmf_pkg::WIN_W-1:0]        half;
    logic [MAX_WINDOW-1:0]            row_ok;
    logic [MAX_WINDOW-1:0][SLOT_W-1:0] row_slot;
    logic                             issuing;
    logic                             col_ok;
    logic                             out_load;
    logic [WIN_N-1:0]                 zb;
    logic [CW-1:0]                    zeros;

    assign half       = cfg.n >> 1;
    assign empty      = !out_valid_reg;
    assign median_out = out_med_reg;
    assign row_last   = out_rl_reg;
    assign frame_last = out_fl_reg;
    assign busy_mask  = (st_reg == ST_LOAD) ? job_reg.mask[RING-1:0] : '0;

    // Rows of the window: in bounds and ring slot
    always_comb
    begin
        int rr;
        for (int s = 0; s < MAX_WINDOW; s++)
        begin
            rr          = int'(job_reg.row) + s - int'(half);
            row_ok[s]   = (s < int'(cfg.n)) && (rr >= 0) && (rr < int'(cfg.h));
            row_slot[s] = SLOT_W'(wmf_pkg::ring_step(int'(job_reg.slot), s - int'(half),
                                                     RING));
        end
    end

    // Issue one column read per cycle
    always_comb
    begin
        int cc;
        cc      = int'(job_reg.col) + int'(t_reg) - int'(half);
        issuing = (st_reg == ST_LOAD) && (int'(t_reg) < int'(cfg.n));
        col_ok  = (cc >= 0) && (cc < int'(cfg.w));
        rd_en   = issuing && col_ok;
        rd_col  = COL_W'(cc);
    end

    // Candidates with a zero in the current bit
    always_comb
    begin
        for (int e = 0; e < WIN_N; e++)
        begin
            zb[e] = cand_reg[e] & ~win_reg[e][b_reg];
        end
        zeros = CW'($countones(zb));
    end

    assign out_load = (st_reg == ST_DONE) && (!out_valid_reg || pop);

    // Next state
    always_comb
    begin
        logic [MAX_WINDOW-1:0] colv;

        st_next    = st_reg;
        job_next   = job_reg;
        t_next     = t_reg;
        rd_v_next  = issuing;
        rd_t_next  = t_reg;
        rd_ok_next = col_ok;
        win_next   = win_reg;
        vld_next   = vld_reg;
        cnt_next   = cnt_reg;
        cand_next  = cand_reg;
        k_next     = k_reg;
        b_next     = b_reg;
        res_next   = res_reg;
        q_pop      = 1'b0;
        colv       = '0;

        // Capture the column read last cycle
        if (rd_v_reg)
        begin
            for (int s = 0; s < MAX_WINDOW; s++)
            begin
                colv[s] = row_ok[s] && rd_ok_reg;
                for (int tt = 0; tt < MAX_WINDOW; tt++)
                begin
                    if (rd_t_reg == NW'(tt))
                    begin
                        win_next[s * MAX_WINDOW + tt] = rd_data[row_slot[s]];
                        vld_next[s * MAX_WINDOW + tt] = colv[s];
                    end
                end
            end
            cnt_next = cnt_reg + CW'($countones(colv));
        end

        unique case (st_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    job_next = q_head;
                    vld_next = '0;
                    cnt_next = '0;
                    t_next   = '0;
                    st_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (issuing)
                begin
                    t_next = t_reg + NW'(1);
                end
                else
                begin
                    cand_next = vld_next;
                    k_next    = cnt_next >> 1;
                    b_next    = BW'(PIXEL_BITS - 1);
                    res_next  = '0;
                    st_next   = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                if (k_reg < zeros)
                begin
                    cand_next = zb;
                    res_next  = res_reg << 1;
                end
                else
                begin
                    cand_next = cand_reg & ~zb;
                    k_next    = k_reg - zeros;
                    res_next  = (res_reg << 1) | PIXEL_BITS'(1);
                end
                if (b_reg == '0)
                begin
                    st_next = ST_DONE;
                end
                else
                begin
                    b_next = b_reg - BW'(1);
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase

        // Output register: fill on load, drop on pop
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        rd_t_reg <= rd_t_next;
        rd_ok_reg <= rd_ok_next;
        win_reg  <= win_next;
        vld_reg  <= vld_next;
        cnt_reg  <= cnt_next;
        cand_reg <= cand_next;
        k_reg    <= k_next;
        b_reg    <= b_next;
        res_reg  <= res_next;
        if (out_load)
        begin
            out_med_reg <= wmf_pkg::PORT_PIX_W'(res_reg);
            out_rl_reg  <= job_reg.row_last;
            out_fl_reg  <= job_reg.frame_last;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            t_reg         <= '0;
            rd_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            t_reg         <= t_next;
            rd_v_reg      <= rd_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The rank being searched always lies among the candidates
    a_rank_in_cand: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_SELECT) |-> (int'(k_reg) < $countones(cand_reg)))
        else $error("median rank outside candidate set");

    // Reads are only issued while gathering a window
    a_read_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (st_reg == ST_LOAD) && (busy_mask != '0))
        else $error("line store read outside window gather");

endmodule

// ----- hw/rtl/windowed_median_filter.sv -----
// Path: a result follows its releasing input beat through the job queue, the window
//   column reads, the bit-by-bit select steps and the output register.
// Throughput: input takes one beat per cycle while the job queue has room and no queued
//   or loading job reads the line store slot being written; the single window
//   gather/select unit takes a new job only after the last one has left for the output register.
// Reset: counters and control clear, registers take their defaults; the line store
//   is not cleared, only written rows are ever read.
// ----------------------------------------------------------------------------
// windowed_median_filter
// Streaming 2-D median filter over a clipped n-by-n window, raster order.
// ----------------------------------------------------------------------------
module windowed_median_filter #(
    parameter int MAX_WINDOW = 7,
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wmf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wmf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic                                action,
    input  logic [wmf_pkg::PORT_PIX_W-1:0]      pixel_in,
    output logic                                empty,
    input  logic                                pop,
    output logic [wmf_pkg::PORT_PIX_W-1:0]      median_out,
    output logic                                row_last,
    output logic                                frame_last
);

    localparam int RING   = MAX_WINDOW + 1;
    localparam int SLOT_W = $clog2(RING);
    localparam int COL_W  = $clog2(MAX_WIDTH);

    wmf_pkg::cfg_t                  cfg;
    wmf_pkg::job_t                  job;
    wmf_pkg::job_t                  q_head;
    logic                           job_valid;
    logic                           q_full;
    logic                           q_empty;
    logic                           q_pop;
    logic [RING-1:0]                q_mask;
    logic [RING-1:0]                busy_mask;
    logic                           wr_en;
    logic [SLOT_W-1:0]              wr_slot;
    logic [COL_W-1:0]               wr_col;
    logic [PIXEL_BITS-1:0]          wr_data;
    logic                           rd_en;
    logic [COL_W-1:0]               rd_col;
    logic [RING-1:0][PIXEL_BITS-1:0] rd_data;

    wmf_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .action    (action),
        .pixel_in  (pixel_in),
        .full      (full),
        .q_full    (q_full),
        .pend_mask (q_mask | busy_mask),
        .job_valid (job_valid),
        .job       (job),
        .wr_en     (wr_en),
        .wr_slot   (wr_slot),
        .wr_col    (wr_col),
        .wr_data   (wr_data),
        .cfg       (cfg)
    );

    wmf_job_queue #(
        .RING (RING)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_valid),
        .din     (job),
        .pop     (q_pop),
        .dout    (q_head),
        .full    (q_full),
        .empty   (q_empty),
        .mask_or (q_mask)
    );

    // One line store bank per ring slot
    for (genvar g = 0; g < RING; g++)
    begin : g_bank
        wmf_ram #(
            .WIDTH (PIXEL_BITS),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .clk   (clk),
            .we    (wr_en && (wr_slot == SLOT_W'(g))),
            .waddr (wr_col),
            .wdata (wr_data),
            .re    (rd_en),
            .raddr (rd_col),
            .rdata (rd_data[g])
        );
    end

    wmf_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .busy_mask  (busy_mask),
        .rd_en      (rd_en),
        .rd_col     (rd_col),
        .rd_data    (rd_data),
        .pop        (pop),
        .empty      (empty),
        .median_out (median_out),
        .row_last   (row_last),
        .frame_last (frame_last)
    );

endmodule

// ----- dv/tb_windowed_median_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_median_filter
// Streams raster frames and flush ticks through the median filter under
// random idling on both sides, predicts every median with a software copy
// of the window logic and checks each result beat in order.
// ----------------------------------------------------------------------------
module tb_windowed_median_filter;

    localparam int RING      = 8;
    localparam int STORE_W   = 1024;
    localparam int CYCLE_CAP = 1000000;
    localparam int SETTLE    = 40;

    typedef struct {
        logic [7:0] median;
        logic       row_end;
        logic       frame_end;
    } median_beat_t;

    // ------------------------------------------------------------------------
    // Scoreboard: window predictor plus queue of expected medians
    // ------------------------------------------------------------------------
    class median_scoreboard;
        logic [7:0]   line_mem [RING*STORE_W];
        int           in_row, in_col, out_row, out_col;
        bit           in_ahead;
        logic [2:0]   win_reg;
        logic [10:0]  width_reg;
        logic [12:0]  height_reg;
        median_beat_t expected_q [$];
        int           errors;
        int           items;

        function new();
            win_reg    = 3'd3;
            width_reg  = 11'd1024;
            height_reg = 13'd1024;
            errors     = 0;
            items      = 0;
            restart();
        endfunction

        function void restart();
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
            in_ahead = 0;
        endfunction

        function int win_n();
            return (win_reg < 1) ? 1 : win_reg;
        endfunction

        function int width_eff();
            if (width_reg < 1) return 1;
            return (width_reg > 1024) ? 1024 : width_reg;
        endfunction

        function int height_eff();
            if (height_reg < 1) return 1;
            return (height_reg > wmf_pkg::MAX_HEIGHT) ? wmf_pkg::MAX_HEIGHT : height_reg;
        endfunction

        function void write_reg(wmf_pkg::cfg_idx_t idx, logic [12:0] val);
            case (idx)
                wmf_pkg::CFG_WINDOW: win_reg    = val[2:0];
                wmf_pkg::CFG_WIDTH:  width_reg  = val[10:0];
                wmf_pkg::CFG_HEIGHT: height_reg = val;
                default: ;
            endcase
            restart();
        endfunction

        function bit median_ready();
            int n, w, h, below, nr, nc;
            n = win_n(); w = width_eff(); h = height_eff();
            below = n - 1 - n / 2;
            nr = out_row + below;
            nc = out_col + below;
            if (in_ahead) return 1;
            if (nr > h - 1) nr = h - 1;
            if (nc > w - 1) nc = w - 1;
            return (in_row * w + in_col) > (nr * w + nc);
        endfunction

        // Would a flush tick give a result right now?
        function bit flush_yields();
            if (!in_ahead && out_row == 0 && out_col == 0 && in_row == 0 && in_col == 0)
                return 0;
            return median_ready();
        endfunction

        function median_beat_t window_median();
            median_beat_t b;
            int n, w, h, half, cnt, r, c, k, v;
            int vals [49];
            n = win_n(); w = width_eff(); h = height_eff();
            half = n / 2;
            cnt = 0;
            for (int s = 0; s < n; s++) begin
                r = out_row + s - half;
                if (r < 0 || r >= h) continue;
                for (int t = 0; t < n; t++) begin
                    c = out_col + t - half;
                    if (c < 0 || c >= w) continue;
                    v = line_mem[(r % RING) * STORE_W + c];
                    k = cnt;
                    while (k > 0 && vals[k-1] > v) begin
                        vals[k] = vals[k-1];
                        k--;
                    end
                    vals[k] = v;
                    cnt++;
                end
            end
            b.median    = 8'(vals[cnt/2]);
            b.row_end   = (out_col == w - 1);
            b.frame_end = (out_col == w - 1) && (out_row == h - 1);
            // advance output position
            if (out_col >= w - 1) begin
                out_col = 0;
                if (out_row >= h - 1) begin
                    out_row  = 0;
                    in_ahead = 0;
                end
                else out_row++;
            end
            else out_col++;
            return b;
        endfunction

        // Note one accepted input beat
        function void note_input(logic act, logic [7:0] pix);
            int w, h;
            w = width_eff(); h = height_eff();
            items++;
            if (act == 1'b0) begin
                if (in_ahead) begin
                    out_row = 0; out_col = 0; in_ahead = 0;
                end
                line_mem[(in_row % RING) * STORE_W + in_col] = pix;
                if (in_col >= w - 1) begin
                    in_col = 0;
                    if (in_row >= h - 1) begin
                        in_row   = 0;
                        in_ahead = 1;
                    end
                    else in_row++;
                end
                else in_col++;
            end
            else if (!flush_yields()) begin
                return;
            end
            if (median_ready()) expected_q.push_back(window_median());
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        // Check one accepted result beat
        task check_result(logic [7:0] med, logic rl, logic fl);
            median_beat_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected beat median=%0d", med));
                return;
            end
            e = expected_q.pop_front();
            if (med !== e.median)
                report($sformatf("median got %0d want %0d", med, e.median));
            if (rl !== e.row_end)
                report($sformatf("row_last got %b want %b", rl, e.row_end));
            if (fl !== e.frame_end)
                report($sformatf("frame_last got %b want %b", fl, e.frame_end));
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [wmf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [wmf_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           push;
    logic                           full;
    logic                           action;
    logic [wmf_pkg::PORT_PIX_W-1:0] pixel_in;
    logic                           empty;
    logic                           pop;
    logic [wmf_pkg::PORT_PIX_W-1:0] median_out;
    logic                           row_last;
    logic                           frame_last;

    median_scoreboard sb;
    int cycles;
    int hold_pop;
    int stall_left;

    windowed_median_filter DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .action     (action),
        .pixel_in   (pixel_in),
        .empty      (empty),
        .pop        (pop),
        .median_out (median_out),
        .row_last   (row_last),
        .frame_last (frame_last)
    );

    // Clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Abort a hung run
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    // Result side: check accepted beats, then pick next pop with stalls
    initial
    begin
        pop        = 1'b0;
        hold_pop   = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                sb.check_result(median_out, row_last, frame_last);
            if (hold_pop > 0)
            begin
                pop <= 1'b0;
                hold_pop--;
            end
            else if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
                if ((cycles / 2000) % 3 != 0) stall_left = pick_gap();
            end
        end
    end

    // Offer one beat and hold it until accepted
    task automatic send_beat(logic act, logic [7:0] pix);
        int gap;
        push     <= 1'b1;
        action   <= act;
        pixel_in <= pix;
        do @(posedge clk); while (full);
        sb.note_input(act, pix);
        gap = ((cycles / 1500) % 4 == 1) ? 0 : pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop push and wait until every expected beat is out, then settle
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(wmf_pkg::cfg_idx_t idx, logic [12:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic configure(logic [12:0] n, logic [12:0] w, logic [12:0] h);
        write_reg(wmf_pkg::CFG_WINDOW, n);
        write_reg(wmf_pkg::CFG_WIDTH, w);
        write_reg(wmf_pkg::CFG_HEIGHT, h);
    endtask

    task automatic flush_out();
        while (sb.flush_yields()) send_beat(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // Send npix raster pixels with occasional flush ticks mixed in
    task automatic send_pixels(int npix, int flush_pct);
        for (int i = 0; i < npix; i++)
        begin
            if ($urandom_range(0, 99) < flush_pct)
                send_beat(1'b1, 8'($urandom_range(0, 255)));
            send_beat(1'b0, 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int n, w, h, frames, fsize, phase;
        bit big_done;
        sb        = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = wmf_pkg::CFG_WINDOW;
        cfg_data  = '0;
        push      = 1'b0;
        action    = 1'b0;
        pixel_in  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Flush with nothing ready, then a few pixels under reset settings
        send_beat(1'b1, 8'd0);
        send_beat(1'b0, 8'd0);
        send_beat(1'b0, 8'd255);
        send_beat(1'b0, 8'hA5);
        send_beat(1'b1, 8'h5A);
        wait_idle();

        // Largest window on a small frame with extreme pixels
        configure(13'd7, 13'd4, 13'd3);
        for (int i = 0; i < 12; i++) send_beat(1'b0, (i % 3 == 0) ? 8'd0 : 8'd255);
        flush_out();
        wait_idle();

        // Zero registers act as one: single pixel frames
        configure(13'd0, 13'd0, 13'd0);
        send_beat(1'b0, 8'd255);
        send_beat(1'b0, 8'd1);
        send_beat(1'b1, 8'd0);
        wait_idle();

        // Random phases
        phase    = 0;
        big_done = 0;
        while (sb.items < 1650)
        begin
            n = $urandom_range(0, 7);
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            case ($urandom_range(0, 19))
                0: w = 0;
                1: h = 0;
                2: w = 1024;
                3: w = 2047;
                4: h = 8191;
                5: h = 4096;
                default: ;
            endcase
            if (!big_done && sb.items > 700)
            begin
                n = 1; w = 2047; h = 1;
                big_done = 1;
            end
            configure(13'(n), 13'(w), 13'(h));
            fsize = sb.width_eff() * sb.height_eff();
            frames = (fsize > 1024) ? 1 : $urandom_range(1, 3);
            if (phase == 3) hold_pop = 400;
            for (int f = 0; f < frames; f++)
            begin
                send_pixels((fsize > 1024) ? 60 : fsize, 8);
                // Sometimes start the next frame while outputs are pending
                if (f < frames - 1 && $urandom_range(0, 3) == 0) continue;
                flush_out();
            end
            wait_idle();
            phase++;
        end

        wait_idle();
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
